[design/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mhpq_pkg.sv]
// Types and constants for the min-heap priority queue.
`default_nettype none

package mhpq_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int KEY_W        = 32;
    localparam int ENTRY_CNT_W  = 7;

    typedef logic signed [KEY_W-1:0] key_t;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FULL_DROP   = 2'd1,
        ST_EMPTY_IGNOR = 2'd2
    } status_t;

    typedef struct packed {
        action_t action;
        key_t    value;
    } mhpq_in_t;

    typedef struct packed {
        key_t                   min_value;
        logic [ENTRY_CNT_W-1:0] entry_count;
        logic                   is_empty;
        status_t                status;
    } mhpq_out_t;

    // Broadcast from the controller to every cell in the row
    typedef struct packed {
        logic    load;
        action_t op;
        key_t    value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[design/mhpq_cell.sv]
// One cell of the sorted key row: holds a key, shifts toward either neighbor.
`default_nettype none

module mhpq_cell
    import mhpq_pkg::*;
(
    input  wire logic       aclk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       occupied,
    input  wire key_t       key_left,
    input  wire logic       pred_left,
    input  wire key_t       key_right,
    output key_t            key,
    output logic            pred
);

    key_t key_reg;
    key_t key_next;

    // pred: new key lands at or before this cell; monotone along the row
    assign pred = !occupied || ($signed(key_reg) > $signed(ctrl.value));
    assign key  = key_reg;

    always_comb begin
        key_next = key_reg;
        if (ctrl.op == ACT_INSERT) begin
            if (pred) begin
                key_next = pred_left ? key_left : ctrl.value;
            end
        end else begin
            key_next = key_right;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            key_reg <= key_next;
        end
    end

endmodule

`default_nettype wire

[design/min_heap_priority_queue.sv]
// Top level of the min-heap priority queue: sorted cell row, count and result register.
//
//   channel | direction | payload     | handshake
//   s_      | in        | mhpq_in_t   | s_valid / s_ready
//   m_      | out       | mhpq_out_t  | m_valid / m_ready
//
// One item per cycle unless a pending result is stalled: every cell compares its
// key with the new key in parallel and shifts one place.
// The result shows in the cycle after the transfer and holds until taken.
// Reset (aresetn low, synchronous) empties the queue and drops any result.
// A stalled result blocks new items only while m_ready stays low.
`default_nettype none

module min_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire mhpq_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output mhpq_out_t      m_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    status_t             status_reg;
    status_t             status_next;
    logic                accept;
    logic                is_full;
    logic                is_empty;
    cell_ctrl_t          ctrl;
    logic [CAPACITY-1:0] occupied;
    logic [CAPACITY-1:0] cell_pred;
    key_t                cell_key [CAPACITY];

    assign s_ready  = !out_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    always_comb begin
        count_next  = count_reg;
        status_next = ST_OK;
        ctrl.op     = s_data.action;
        ctrl.value  = s_data.value;
        ctrl.load   = 1'b0;
        if (s_data.action == ACT_INSERT) begin
            if (is_full) begin
                status_next = ST_FULL_DROP;
            end else begin
                ctrl.load  = accept;
                count_next = count_reg + 1'b1;
            end
        end else begin
            if (is_empty) begin
                status_next = ST_EMPTY_IGNOR;
            end else begin
                ctrl.load  = accept;
                count_next = count_reg - 1'b1;
            end
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        key_t left_key;
        logic left_pred;
        key_t right_key;

        assign occupied[i] = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_head
            assign left_key  = '0;
            assign left_pred = 1'b0;
        end else begin : g_body
            assign left_key  = cell_key[i-1];
            assign left_pred = cell_pred[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_key = cell_key[i];
        end else begin : g_inner
            assign right_key = cell_key[i+1];
        end

        mhpq_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .occupied  (occupied[i]),
            .key_left  (left_key),
            .pred_left (left_pred),
            .key_right (right_key),
            .key       (cell_key[i]),
            .pred      (cell_pred[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
        end
    end

    // Result fields come straight from state, which only moves on a transfer
    assign m_valid            = out_valid_reg;
    assign m_data.min_value   = is_empty ? '0 : cell_key[0];
    assign m_data.entry_count = ENTRY_CNT_W'(count_reg);
    assign m_data.is_empty    = is_empty;
    assign m_data.status      = status_reg;

endmodule

`default_nettype wire

[design/mhpq_checker.sv]
// Port-level checker for the min-heap priority queue, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module mhpq_checker
    import mhpq_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire mhpq_in_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire mhpq_out_t m_data
);

    logic s_xfer;
    logic m_stall;
    logic ins_xfer;

    assign s_xfer   = s_valid && s_ready;
    assign m_stall  = m_valid && !m_ready;
    assign ins_xfer = s_xfer && (s_data.action == ACT_INSERT);

    `ASSERT_NEXT(a_result_holds, aclk, aresetn, m_stall, m_valid && $stable(m_data), "result changed while stalled")
    `ASSERT_NEXT(a_result_follows, aclk, aresetn, s_xfer, m_valid, "no result after input transfer")
    `ASSERT_SAME(a_empty_fields, aclk, aresetn, m_valid && m_data.is_empty, (m_data.entry_count == '0) && (m_data.min_value == '0), "empty result with nonzero fields")
    `ASSERT_NEXT(a_insert_min, aclk, aresetn, ins_xfer, (m_data.status == ST_FULL_DROP) || ($signed(m_data.min_value) <= $signed($past(s_data.value))), "minimum above inserted key")
    `ASSERT_SAME(a_ignore_empty, aclk, aresetn, m_valid && (m_data.status == ST_EMPTY_IGNOR), m_data.is_empty, "ignored remove on nonempty queue")

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

[tb/sv/tb_min_heap_priority_queue.sv]
// Testbench for the min-heap priority queue: heap predictor, scoreboard, directed and random traffic.
`timescale 1ns / 100ps

module tb_min_heap_priority_queue;
    import mhpq_pkg::*;

    localparam int QUEUE_DEPTH    = DEF_CAPACITY;
    localparam int RANDOM_ITEMS   = 1280;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;

    typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} load_mix_t;

    // Keeps a binary heap of its own and compares each result against it.
    class heap_scoreboard;
        key_t        keys[QUEUE_DEPTH];
        int unsigned fill;
        mhpq_out_t   expected_q[$];
        int unsigned mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            mismatches++;
            $display("ERROR @%0t: %s", $time, msg);
        endtask

        function void swap_keys(int unsigned a, int unsigned b);
            key_t t;
            t       = keys[a];
            keys[a] = keys[b];
            keys[b] = t;
        endfunction

        function void float_up(int unsigned pos);
            int unsigned parent;
            while (pos > 0) begin
                parent = (pos - 1) / 2;
                if (!(keys[pos] < keys[parent])) break;
                swap_keys(pos, parent);
                pos = parent;
            end
        endfunction

        // On equal children the right one is taken; swap only on strictly less.
        function void sink_down(int unsigned pos);
            int unsigned left;
            int unsigned pick;
            forever begin
                left = 2 * pos + 1;
                if (left >= fill) return;
                pick = left;
                if (left + 1 < fill && !(keys[left] < keys[left + 1])) pick = left + 1;
                if (!(keys[pick] < keys[pos])) return;
                swap_keys(pos, pick);
                pos = pick;
            end
        endfunction

        function void note_input(mhpq_in_t item);
            status_t   st;
            mhpq_out_t exp_res;
            st = ST_OK;
            if (item.action == ACT_INSERT) begin
                if (fill >= QUEUE_DEPTH) begin
                    st = ST_FULL_DROP;
                end else begin
                    keys[fill] = item.value;
                    fill++;
                    float_up(fill - 1);
                end
            end else if (fill == 0) begin
                st = ST_EMPTY_IGNOR;
            end else begin
                fill--;
                keys[0] = keys[fill];
                sink_down(0);
            end
            exp_res.min_value   = (fill > 0) ? keys[0] : '0;
            exp_res.entry_count = fill[ENTRY_CNT_W-1:0];
            exp_res.is_empty    = (fill == 0);
            exp_res.status      = st;
            expected_q = {expected_q, exp_res};
        endfunction

        task check_result(mhpq_out_t got);
            mhpq_out_t exp_res;
            if (expected_q.size() == 0) begin
                report("result transfer with nothing outstanding");
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.min_value !== exp_res.min_value)
                report($sformatf("min_value got %0d want %0d",
                                 got.min_value, exp_res.min_value));
            if (got.entry_count !== exp_res.entry_count)
                report($sformatf("entry_count got %0d want %0d",
                                 got.entry_count, exp_res.entry_count));
            if (got.is_empty !== exp_res.is_empty)
                report($sformatf("is_empty got %0b want %0b",
                                 got.is_empty, exp_res.is_empty));
            if (got.status !== exp_res.status)
                report($sformatf("status got %0d want %0d",
                                 got.status, exp_res.status));
        endtask
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    mhpq_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    mhpq_out_t m_data;

    heap_scoreboard sb = new();

    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    logic        rx_hold_req;
    logic        rx_hold_done;
    int unsigned quiet_cycles;

    min_heap_priority_queue #(
        .CAPACITY(QUEUE_DEPTH)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        m_ready      = 1'b0;
        rx_hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req && !rx_hold_done) begin
                rx_hold_done = 1'b1;
                m_ready      = 1'b0;
                repeat (HOLD_OFF_LEN - 1) @(negedge aclk);
            end else begin
                m_ready = ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // Checks results and watches for a stuck handshake.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("min_heap_priority_queue: mismatch");
                    $finish;
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input mhpq_in_t item);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(item);
        @(negedge aclk);
    endtask

    task automatic send_op(input action_t act, input key_t key);
        mhpq_in_t item;
        item.action = act;
        item.value  = key;
        send_item(item);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic set_idling(input int unsigned sel);
        case (sel % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 73; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 73; end
            default: begin src_idle_pct = 12; snk_stall_pct = 12; end
        endcase
    endtask

    function automatic key_t pick_key();
        case ($urandom_range(9))
            0: return key_t'(32'h8000_0000);
            1: return key_t'(32'h7FFF_FFFF);
            2: return key_t'($urandom_range(1)) - key_t'(1);
            3, 4, 5: return key_t'($urandom_range(15)) - key_t'(8);   // many duplicates
            default: return key_t'($urandom);
        endcase
    endfunction

    function automatic mhpq_in_t make_item(input load_mix_t mix);
        mhpq_in_t    item;
        int unsigned insert_pct;
        case (mix)
            MIX_FILL:  insert_pct = 85;
            MIX_DRAIN: insert_pct = 15;
            default:   insert_pct = 50;
        endcase
        item.action = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
        item.value  = pick_key();
        return item;
    endfunction

    initial begin
        load_mix_t mix;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        rx_hold_req   = 1'b0;
        quiet_cycles  = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty remove, extreme keys, ties, drain back past empty.
        send_op(ACT_REMOVE, key_t'(32'h1234_5678));
        send_op(ACT_INSERT, key_t'(0));
        send_op(ACT_INSERT, key_t'(32'h7FFF_FFFF));
        send_op(ACT_INSERT, key_t'(32'h8000_0000));
        send_op(ACT_INSERT, key_t'(-1));
        send_op(ACT_INSERT, key_t'(7));
        send_op(ACT_INSERT, key_t'(7));
        send_op(ACT_REMOVE, key_t'(32'hFFFF_FFFF));
        send_op(ACT_REMOVE, key_t'(0));
        send_op(ACT_INSERT, key_t'(1));
        send_op(ACT_INSERT, key_t'(1));
        send_op(ACT_INSERT, key_t'(1));
        send_op(ACT_REMOVE, key_t'(0));
        repeat (8) send_op(ACT_REMOVE, key_t'(0));
        send_op(ACT_REMOVE, key_t'(32'h5555_5555));
        send_op(ACT_INSERT, key_t'(32'hAAAA_AAAA));
        send_op(ACT_REMOVE, key_t'(0));

        // Random: load mix and idling change on different periods.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 160 == 0) set_idling(i / 160);
            case ((i / 110) % 4)
                0:       mix = MIX_FILL;
                2:       mix = MIX_DRAIN;
                default: mix = MIX_BALANCED;
            endcase
            if (i == 400) rx_hold_req = 1'b1;   // input must back up behind the stall
            if (i == 800) wait_drained();
            send_item(make_item(mix));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.mismatches == 0) begin
            $display("min_heap_priority_queue: match");
        end else begin
            $display("min_heap_priority_queue: mismatch");
        end
        $finish;
    end

endmodule
